>>> rtl/assert_macros.svh
// assertion macros shared by the rtl of the dither block
// no dependencies; the bodies drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/htdb_pkg.sv
// constants, types and step functions of the hash triangular dither pipeline
// no dependencies
`timescale 1ns / 1ps

package htdb_pkg;

	localparam int CHANNEL_FRAC_BITS_DEF = 12;
	localparam int CHAN_W    = 16;
	localparam int XY_W      = 16;
	localparam int BYTE_W    = 8;
	localparam int STRENGTH_W = 16;
	localparam int NUM_CHAN  = 3;

	localparam logic [31:0] HASH_MUL       = 32'd1103515245;
	localparam logic [15:0] TRI_SCALE_Q24  = 16'd55365;
	localparam logic [STRENGTH_W-1:0] STRENGTH_RESET = 16'd4096;
	localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hff;

	// noise product: q1.16 magnitude x q0.24 scale x q4.12 strength = q52
	localparam int SCALED_W    = 33;
	localparam int PROD_W      = SCALED_W + STRENGTH_W;
	localparam int TOTAL_SHIFT = 52;

	// square root unit: 32 root bits, two per pipeline stage
	localparam int SQRT_ROOT_W = 32;
	localparam int SQ_REM_W    = SQRT_ROOT_W + 2;
	localparam int SQRT_STEPS  = 2;
	localparam int SQRT_STAGES = SQRT_ROOT_W / SQRT_STEPS;

	// stage numbers
	localparam int ST_HASH1  = 1;
	localparam int ST_HASH2  = 2;
	localparam int ST_SQ0    = 3;
	localparam int ST_SCALE  = ST_SQ0 + SQRT_STAGES;
	localparam int ST_PROD   = ST_SCALE + 1;
	localparam int ST_NOISE  = ST_PROD + 1;
	localparam int ST_SUM    = ST_NOISE + 1;
	localparam int ST_BYTE   = ST_SUM + 1;
	localparam int NUM_STAGES = ST_BYTE;

	typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] rgb_t;

	typedef struct packed {
		logic [SQ_REM_W-1:0]    rem;
		logic [SQRT_ROOT_W-1:0] root;
		logic [SQRT_ROOT_W-1:0] rad;   // radicand bits still to be consumed, msb first
	} sqrt_state_t;

	// low 32 bits of a 32x32 product
	function automatic logic [31:0] mul_lo32(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = a * b;
		return p[31:0];
	endfunction

	// one restoring step: pull in two radicand bits, decide one root bit
	function automatic sqrt_state_t sqrt_step(input sqrt_state_t st);
		sqrt_state_t nx;
		logic [SQ_REM_W+1:0] acc;
		logic [SQ_REM_W+1:0] trial;
		acc   = {st.rem, st.rad[SQRT_ROOT_W-1 -: 2]};
		trial = {2'b00, st.root, 2'b01};
		nx.rad = {st.rad[SQRT_ROOT_W-3:0], 2'b00};
		if (acc >= trial) begin
			nx.rem  = SQ_REM_W'(acc - trial);
			nx.root = {st.root[SQRT_ROOT_W-2:0], 1'b1};
		end else begin
			nx.rem  = acc[SQ_REM_W-1:0];
			nx.root = {st.root[SQRT_ROOT_W-2:0], 1'b0};
		end
		return nx;
	endfunction

endpackage

>>> rtl/hash_triangular_dither_to_byte.sv
// hash triangular dither of one rgb pixel to three bytes, fully pipelined
// depends on htdb_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// channel   signals                                         direction  notes
// pixel     pix_valid pix_ready pixel_x pixel_y red_in       in         valid/ready
//           green_in blue_in
// byte      byte_valid byte_ready red_byte green_byte        out        valid/ready
//           blue_byte
// config    cfg_wr_en cfg_wr_data                            in         dither strength, no wait
//
// one pixel per clock sustained while byte_ready holds; the bulk of the pipeline is the
//   sixteen stage square root (two root bits per stage) behind the two hash multiplier stages
// arst_n clears every stage valid bit and loads dither strength 1.0 (q4.12)
// a stage takes a new word when byte_ready is high or it or a later stage is empty, so
//   bubbles close up behind a stalled output and words are never dropped or repeated

module hash_triangular_dither_to_byte
	import htdb_pkg::*;
#(
	parameter int CHANNEL_FRAC_BITS = CHANNEL_FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,

	input  logic                    cfg_wr_en,
	input  logic [STRENGTH_W-1:0]   cfg_wr_data,

	input  logic                    pix_valid,
	output logic                    pix_ready,
	input  logic [XY_W-1:0]         pixel_x,
	input  logic [XY_W-1:0]         pixel_y,
	input  logic signed [CHAN_W-1:0] red_in,
	input  logic signed [CHAN_W-1:0] green_in,
	input  logic signed [CHAN_W-1:0] blue_in,

	output logic                    byte_valid,
	input  logic                    byte_ready,
	output logic [BYTE_W-1:0]       red_byte,
	output logic [BYTE_W-1:0]       green_byte,
	output logic [BYTE_W-1:0]       blue_byte
);

	// noise magnitude shift from q52 down to the channel format
	localparam int SHIFT   = TOTAL_SHIFT - CHANNEL_FRAC_BITS;
	localparam int MAG_W   = PROD_W - SHIFT + 1;
	localparam int NOISE_W = MAG_W + 1;
	localparam int SUM_W   = ((CHAN_W > NOISE_W) ? CHAN_W : NOISE_W) + 1;
	localparam int P_W     = SUM_W + 8;
	localparam int HI_W    = P_W - CHANNEL_FRAC_BITS;
	localparam logic [PROD_W:0] RoundMag  = {{PROD_W{1'b0}}, 1'b1} << (SHIFT - 1);
	localparam logic [P_W-1:0]  RoundByte = {{(P_W-1){1'b0}}, 1'b1} << (CHANNEL_FRAC_BITS - 1);

	// config register
	logic [STRENGTH_W-1:0] strength_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strength_q <= STRENGTH_RESET;
		end else if (cfg_wr_en) begin
			strength_q <= cfg_wr_data;
		end
	end

	// stage valid bits and advance enables
	logic [NUM_STAGES:1] vld_s;
	logic [NUM_STAGES:1] vld_in;
	logic [NUM_STAGES:1] adv;

	assign vld_in = {vld_s[NUM_STAGES-1:1], pix_valid};

	// a stage may load if it, or anything downstream of it, has room
	for (genvar k = 1; k <= NUM_STAGES; k++) begin : g_adv
		assign adv[k] = byte_ready || !(&vld_s[NUM_STAGES:k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= (adv & vld_in) | (~adv & vld_s);
		end
	end

	assign pix_ready  = adv[ST_HASH1];
	assign byte_valid = vld_s[ST_BYTE];

	// stage 1: the two coordinate hashes
	logic [31:0] hx_s1, hy_s1;
	rgb_t        chan_s1;

	always_ff @(posedge clk) begin
		if (adv[ST_HASH1]) begin
			hx_s1   <= mul_lo32(HASH_MUL, {16'd0, (pixel_x >> 1) ^ pixel_y});
			hy_s1   <= mul_lo32(HASH_MUL, {16'd0, (pixel_y >> 1) ^ pixel_x});
			chan_s1 <= {blue_in, green_in, red_in};
		end
	end

	// stage 2: combining hash
	logic [31:0] h_s2;
	rgb_t        chan_s2;

	always_ff @(posedge clk) begin
		if (adv[ST_HASH2]) begin
			h_s2    <= mul_lo32(HASH_MUL, hx_s1 ^ (hy_s1 >> 3));
			chan_s2 <= chan_s1;
		end
	end

	// d = 2h - (2^32-1) is odd; its sign is the inverted top hash bit and
	// (2^32-1) - |d| is the low hash bits, conditionally inverted, times two
	logic        neg_h;
	logic [31:0] rad_h;

	assign neg_h = ~h_s2[31];
	assign rad_h = {h_s2[30:0] ^ {31{h_s2[31]}}, 1'b0};

	// square root of rad_h * 2^32, two root bits a stage
	sqrt_state_t sq_st_s   [SQRT_STAGES];
	logic        sq_neg_s  [SQRT_STAGES];
	rgb_t        sq_chan_s [SQRT_STAGES];

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
		sqrt_state_t st_in;
		sqrt_state_t st_out;
		logic        neg_in;
		rgb_t        chan_in;

		if (k == 0) begin : g_first
			assign st_in   = '{rem: '0, root: '0, rad: rad_h};
			assign neg_in  = neg_h;
			assign chan_in = chan_s2;
		end else begin : g_next
			assign st_in   = sq_st_s[k-1];
			assign neg_in  = sq_neg_s[k-1];
			assign chan_in = sq_chan_s[k-1];
		end

		always_comb begin
			st_out = st_in;
			for (int j = 0; j < SQRT_STEPS; j++) begin
				st_out = sqrt_step(st_out);
			end
		end

		always_ff @(posedge clk) begin
			if (adv[ST_SQ0 + k]) begin
				sq_st_s[k]   <= st_out;
				sq_neg_s[k]  <= neg_in;
				sq_chan_s[k] <= chan_in;
			end
		end
	end

	// stage scale: triangular magnitude to q1.16, times 0.0033 in q0.24
	logic [SQRT_ROOT_W:0]  m_rnd;
	logic [16:0]           m16;
	logic [SCALED_W-1:0]   scaled_s19;
	logic                  neg_s19;
	rgb_t                  chan_s19;

	assign m_rnd = {1'b0, ~sq_st_s[SQRT_STAGES-1].root} + 33'h0_0000_8000;
	assign m16   = m_rnd[SQRT_ROOT_W -: 17];

	always_ff @(posedge clk) begin
		if (adv[ST_SCALE]) begin
			scaled_s19 <= SCALED_W'(m16) * SCALED_W'(TRI_SCALE_Q24);
			neg_s19    <= sq_neg_s[SQRT_STAGES-1];
			chan_s19   <= sq_chan_s[SQRT_STAGES-1];
		end
	end

	// stage prod: times dither strength
	logic [PROD_W-1:0] prod_s20;
	logic              neg_s20;
	rgb_t              chan_s20;

	always_ff @(posedge clk) begin
		if (adv[ST_PROD]) begin
			prod_s20 <= PROD_W'(scaled_s19) * PROD_W'(strength_q);
			neg_s20  <= neg_s19;
			chan_s20 <= chan_s19;
		end
	end

	// stage noise: round to channel format, then apply sign
	logic [PROD_W:0]            mag_sum;
	logic [MAG_W-1:0]           mag;
	logic signed [NOISE_W-1:0]  noise_s21;
	rgb_t                       chan_s21;

	assign mag_sum = {1'b0, prod_s20} + RoundMag;
	assign mag     = mag_sum[PROD_W:SHIFT];

	always_ff @(posedge clk) begin
		if (adv[ST_NOISE]) begin
			noise_s21 <= neg_s20 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
			chan_s21  <= chan_s20;
		end
	end

	// stages sum and byte, one lane per channel
	logic signed [SUM_W-1:0] sum_s22  [NUM_CHAN];
	logic [BYTE_W-1:0]       byte_s23 [NUM_CHAN];

	for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
		logic [SUM_W-2:0] pos;
		logic [P_W-1:0]   p255;
		logic [HI_W-1:0]  hi;
		logic [BYTE_W-1:0] byte_d;

		always_ff @(posedge clk) begin
			if (adv[ST_SUM]) begin
				sum_s22[c] <= SUM_W'($signed(chan_s21[c])) + SUM_W'(noise_s21);
			end
		end

		// round to nearest of sum * 255 / 2^frac, clamp to a byte
		assign pos  = sum_s22[c][SUM_W-2:0];
		assign p255 = (P_W'(pos) << 8) - P_W'(pos) + RoundByte;
		assign hi   = p255[P_W-1:CHANNEL_FRAC_BITS];

		always_comb begin
			if (sum_s22[c] <= 0) begin
				byte_d = '0;
			end else if (hi > HI_W'(BYTE_MAX)) begin
				byte_d = BYTE_MAX;
			end else begin
				byte_d = hi[BYTE_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (adv[ST_BYTE]) begin
				byte_s23[c] <= byte_d;
			end
		end
	end

	assign red_byte   = byte_s23[0];
	assign green_byte = byte_s23[1];
	assign blue_byte  = byte_s23[2];

	// an empty output stage never holds off the input
	`ASSERT_IMPL(a_ready_when_out_empty, clk, arst_n, !vld_s[ST_BYTE], pix_ready)
	// an accepted pixel always lands in the first stage
	`ASSERT_NEXT(a_accept_fills_first, clk, arst_n, pix_valid && pix_ready, vld_s[ST_HASH1])
	// a non-positive red sum comes out as zero
	`ASSERT_NEXT(a_nonpos_red_zero, clk, arst_n, vld_s[ST_SUM] && adv[ST_BYTE] && (sum_s22[0] <= 0), red_byte == '0)

endmodule

>>> tb/htdb_byte_checker.sv
// scoreboard for the hash triangular dither block: predicts each byte word
// from the accepted pixel words and compares; depends on htdb_pkg only
`timescale 1ns / 1ps

module htdb_byte_checker
	import htdb_pkg::*;
#(
	parameter int CHANNEL_FRAC_BITS = CHANNEL_FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [STRENGTH_W-1:0]    cfg_wr_data,
	input  logic                     pix_valid,
	input  logic                     pix_ready,
	input  logic [XY_W-1:0]          pixel_x,
	input  logic [XY_W-1:0]          pixel_y,
	input  logic [CHAN_W-1:0]        red_in,
	input  logic [CHAN_W-1:0]        green_in,
	input  logic [CHAN_W-1:0]        blue_in,
	input  logic                     byte_valid,
	input  logic                     byte_ready,
	input  logic [BYTE_W-1:0]        red_byte,
	input  logic [BYTE_W-1:0]        green_byte,
	input  logic [BYTE_W-1:0]        blue_byte,
	output int                       fail_count,
	output int                       pending_words
);

	localparam logic [31:0] COORD_MUL   = 32'd1103515245;
	localparam logic [63:0] DITHER_Q24  = 64'd55365;
	localparam logic [63:0] ONES32      = 64'h0000_0000_ffff_ffff;
	localparam int          NOISE_SHIFT = 52 - CHANNEL_FRAC_BITS;

	typedef struct packed {
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
	} rgb_bytes_t;

	rgb_bytes_t            dithered_q[$];
	logic [STRENGTH_W-1:0] strength_q;

	function automatic logic [31:0] lo_mul(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = {32'd0, a} * {32'd0, b};
		return p[31:0];
	endfunction

	// floor of the square root, digit by digit
	function automatic logic [63:0] root_floor64(input logic [63:0] n);
		logic [63:0] res;
		logic [63:0] bit_w;
		logic [63:0] num;
		res   = '0;
		bit_w = 64'd1 << 62;
		num   = n;
		while (bit_w > num)
			bit_w = bit_w >> 2;
		while (bit_w != 0) begin
			if (num >= res + bit_w) begin
				num = num - (res + bit_w);
				res = (res >> 1) + bit_w;
			end else begin
				res = res >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return res;
	endfunction

	function automatic logic [BYTE_W-1:0] chan_to_byte(input logic [CHAN_W-1:0] chan,
			input logic [63:0] noise);
		logic [63:0] sum;
		logic [63:0] p;
		sum = {{(64-CHAN_W){chan[CHAN_W-1]}}, chan} + noise;
		if (sum[63] || sum == 0)
			return '0;
		p = sum * 64'd255 + (64'd1 << (CHANNEL_FRAC_BITS - 1));
		p = p >> CHANNEL_FRAC_BITS;
		return (p > 64'd255) ? 8'hff : p[7:0];
	endfunction

	function automatic rgb_bytes_t dither_pixel(input logic [XY_W-1:0] x,
			input logic [XY_W-1:0] y, input logic [CHAN_W-1:0] r,
			input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b,
			input logic [STRENGTH_W-1:0] strength);
		logic [31:0] hx;
		logic [31:0] hy;
		logic [31:0] h;
		logic [63:0] d;
		logic        neg;
		logic [63:0] mag_u;
		logic [63:0] root;
		logic [63:0] m16;
		logic [63:0] prod;
		logic [63:0] mag;
		logic [63:0] noise;
		rgb_bytes_t  res;
		hx = lo_mul(COORD_MUL, ({16'd0, x} >> 1) ^ {16'd0, y});
		hy = lo_mul(COORD_MUL, ({16'd0, y} >> 1) ^ {16'd0, x});
		h  = lo_mul(COORD_MUL, hx ^ (hy >> 3));
		// signed uniform value 2h - (2^32-1), always odd
		d     = {31'd0, h, 1'b0} - ONES32;
		neg   = d[63];
		mag_u = neg ? -d : d;
		root  = root_floor64((ONES32 - mag_u) << 32);
		m16   = ((ONES32 - root) + 64'd32768) >> 16;
		prod  = m16 * DITHER_Q24 * {48'd0, strength};
		mag   = (prod + (64'd1 << (NOISE_SHIFT - 1))) >> NOISE_SHIFT;
		noise = neg ? -mag : mag;
		res.red   = chan_to_byte(r, noise);
		res.green = chan_to_byte(g, noise);
		res.blue  = chan_to_byte(b, noise);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rgb_bytes_t want;
		if (!arst_n) begin
			strength_q    <= STRENGTH_RESET;
			fail_count    <= 0;
			pending_words <= 0;
			dithered_q.delete();
		end else begin
			if (cfg_wr_en)
				strength_q <= cfg_wr_data;
			if (byte_valid && byte_ready) begin
				if (dithered_q.size() == 0) begin
					$error("byte word with nothing expected: %0d %0d %0d",
						red_byte, green_byte, blue_byte);
					fail_count <= fail_count + 1;
				end else begin
					want = dithered_q.pop_front();
					if (want.red !== red_byte || want.green !== green_byte ||
							want.blue !== blue_byte)
						fail_count <= fail_count + 1;
					if (want.red !== red_byte)
						$error("red_byte expected %0d actual %0d", want.red, red_byte);
					if (want.green !== green_byte)
						$error("green_byte expected %0d actual %0d", want.green, green_byte);
					if (want.blue !== blue_byte)
						$error("blue_byte expected %0d actual %0d", want.blue, blue_byte);
				end
			end
			if (pix_valid && pix_ready)
				dithered_q.push_back(dither_pixel(pixel_x, pixel_y, red_in, green_in,
					blue_in, strength_q));
			pending_words <= dithered_q.size();
		end
	end

endmodule

>>> tb/tb_hash_triangular_dither_to_byte.sv
// top of the dither block testbench: clock, reset, pixel and byte traffic, strength
// writes and the verdict; depends on htdb_pkg, htdb_byte_checker and the block itself
`timescale 1ns / 1ps

module tb_hash_triangular_dither_to_byte;
	import htdb_pkg::*;

	// pipeline depth of the block, plus some slack for the drain
	localparam int PIPE_LAT    = 23;
	localparam int DRAIN_WAIT  = PIPE_LAT + 8;
	localparam int PHASE_WORDS = 160;
	localparam int NUM_PHASES  = 7;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [STRENGTH_W-1:0] cfg_wr_data;
	logic                  pix_valid;
	logic                  pix_ready;
	logic [XY_W-1:0]       pixel_x;
	logic [XY_W-1:0]       pixel_y;
	logic [CHAN_W-1:0]     red_in;
	logic [CHAN_W-1:0]     green_in;
	logic [CHAN_W-1:0]     blue_in;
	logic                  byte_valid;
	logic                  byte_ready;
	logic [BYTE_W-1:0]     red_byte;
	logic [BYTE_W-1:0]     green_byte;
	logic [BYTE_W-1:0]     blue_byte;
	int                    fail_count;
	int                    pending_words;

	hash_triangular_dither_to_byte u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.pix_valid   (pix_valid),
		.pix_ready   (pix_ready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.red_in      (red_in),
		.green_in    (green_in),
		.blue_in     (blue_in),
		.byte_valid  (byte_valid),
		.byte_ready  (byte_ready),
		.red_byte    (red_byte),
		.green_byte  (green_byte),
		.blue_byte   (blue_byte)
	);

	htdb_byte_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.pix_valid     (pix_valid),
		.pix_ready     (pix_ready),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.red_in        (red_in),
		.green_in      (green_in),
		.blue_in       (blue_in),
		.byte_valid    (byte_valid),
		.byte_ready    (byte_ready),
		.red_byte      (red_byte),
		.green_byte    (green_byte),
		.blue_byte     (blue_byte),
		.fail_count    (fail_count),
		.pending_words (pending_words)
	);

	// 8 ns clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// hard stop far beyond the slowest legal run
	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

	// present one pixel word and hold it until the block takes it;
	// valid stays high afterwards, the caller lowers it when a gap follows
	task automatic send_pixel(input logic [XY_W-1:0] x, input logic [XY_W-1:0] y,
			input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
			input logic [CHAN_W-1:0] b);
		pix_valid <= 1'b1;
		pixel_x   <= x;
		pixel_y   <= y;
		red_in    <= r;
		green_in  <= g;
		blue_in   <= b;
		do
			@(posedge clk);
		while (!pix_ready);
	endtask

	// stop sending and wait until every predicted byte word has come back,
	// then let the pipe settle before anything else happens
	task automatic drain_pipe();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (pending_words != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// strength is only ever changed on an empty pipe
	task automatic write_strength(input logic [STRENGTH_W-1:0] value);
		drain_pipe();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// channel values bunched where the byte mapping is interesting:
	// around zero, around one, across the visible range, and the full 16 bits
	function automatic logic [CHAN_W-1:0] pick_channel();
		int v;
		case ($urandom_range(0, 9))
			0, 1:    v = $urandom_range(0, 65535);
			2:       v = int'($urandom_range(0, 400)) - 200;
			3:       v = 4096 + int'($urandom_range(0, 600)) - 300;
			default: v = $urandom_range(0, 4200);
		endcase
		return CHAN_W'(v);
	endfunction

	function automatic logic [XY_W-1:0] pick_coord();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return '1;
			2:       return XY_W'($urandom_range(0, 15));
			default: return XY_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// receiver: ready pattern is picked at random among always ready, mostly ready,
	// mostly stalled and a periodic stall window
	initial begin
		int rx_cycle;
		int rx_mode;
		byte_ready = 1'b0;
		rx_cycle   = 0;
		rx_mode    = 0;
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (rx_cycle % 53 == 0)
				rx_mode = $urandom_range(0, 3);
			case (rx_mode)
				0:       byte_ready <= 1'b1;
				1:       byte_ready <= ($urandom_range(0, 3) != 0);
				2:       byte_ready <= ($urandom_range(0, 3) == 0);
				default: byte_ready <= ((rx_cycle % 8) >= 3);
			endcase
		end
	end

	// sender and verdict
	initial begin
		logic [STRENGTH_W-1:0] phase_strength;
		int burst_left;
		int gap;
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		pix_valid   = 1'b0;
		pixel_x     = '0;
		pixel_y     = '0;
		red_in      = '0;
		green_in    = '0;
		blue_in     = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words at the reset strength of 1.0
		send_pixel(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_pixel(16'hffff, 16'hffff, 16'h7fff, 16'h7fff, 16'h7fff);
		send_pixel(16'd0, 16'hffff, 16'h8000, 16'h8000, 16'h8000);
		send_pixel(16'hffff, 16'd0, 16'd4096, 16'd4095, 16'd4097);
		// negative and tiny positive channels next to each other
		send_pixel(16'd1, 16'd0, 16'hffff, 16'd1, 16'd2);
		// one byte step is about 16 counts, half a step around 8
		send_pixel(16'd0, 16'd1, 16'd8, 16'd16, 16'd24);
		send_pixel(16'd123, 16'd456, 16'd4080, 16'd4100, 16'd2048);
		// near one, so noise can push past 255
		send_pixel(16'd7, 16'd9, 16'd4088, 16'd4090, 16'd4094);
		send_pixel(16'haaaa, 16'h5555, 16'h5555, 16'haaaa, 16'h0f0f);
		send_pixel(16'h5555, 16'haaaa, 16'hf0f0, 16'h00ff, 16'hff00);
		send_pixel(16'd2, 16'd3, 16'hfff0, 16'd3, 16'd200);
		send_pixel(16'd1000, 16'd2000, 16'd1234, 16'd2345, 16'd3456);
		drain_pipe();

		// the largest strength on words near both ends of the clamp
		write_strength(16'hffff);
		send_pixel(16'd0, 16'd0, 16'd4, 16'd12, 16'd4000);
		send_pixel(16'hffff, 16'hffff, 16'd4095, 16'd1, 16'd2040);
		send_pixel(16'd31, 16'd17, 16'd100, 16'd4200, 16'hffe0);
		send_pixel(16'd8, 16'd0, 16'd0, 16'd4096, 16'd30);

		// random phases, each at its own strength, with zero, the smallest step
		// and the reset value among them; the pipe drains between phases so the
		// sender also sits idle until nothing is outstanding
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0:       phase_strength = 16'd0;
				1:       phase_strength = 16'hffff;
				2:       phase_strength = 16'd1;
				3:       phase_strength = 16'h8000;
				4:       phase_strength = 16'd4096;
				default: phase_strength = STRENGTH_W'($urandom_range(0, 65535));
			endcase
			write_strength(phase_strength);
			burst_left = 0;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (burst_left == 0) begin
					// one phase in three runs back to back without gaps
					if (ph % 3 == 1) begin
						burst_left = PHASE_WORDS;
						gap        = 0;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap        = $urandom_range(0, 12);
					end
					if (gap != 0) begin
						pix_valid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
				end
				send_pixel(pick_coord(), pick_coord(), pick_channel(), pick_channel(),
					pick_channel());
				burst_left--;
			end
		end

		drain_pipe();
		if (fail_count == 0 && pending_words == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
